/* hdl/ata_pkg.sv */
`default_nettype none

package ata_pkg;

  // Converter sample width and the value that fills the window after reset.
  localparam int unsigned SAMPLE_W     = 12;
  localparam int unsigned RESET_SAMPLE = 25;

  // Default averaging depth.
  localparam int unsigned AVG_DEPTH_DEF = 8;

  // Temperature and threshold width, two's complement.
  localparam int unsigned TEMP_W = 9;

  // Degrees are trunc((2508 - avg) * 25 / 269).
  // The offset difference always fits a 13-bit signed value.
  localparam int unsigned DIFF_W = 13;
  localparam logic signed [DIFF_W-1:0] CONV_OFFSET = 13'sd2508;

  // The scaled magnitude |diff| * 25 never exceeds 62700, which fits 16 bits.
  localparam int unsigned SCALED_W = 16;

  // Exact reciprocal of 269 for 16-bit numerators: ceil(2^25 / 269).
  localparam int unsigned CONV_SH    = 25;
  localparam int unsigned CONV_RCP_W = 17;
  localparam logic [CONV_RCP_W-1:0] CONV_RCP = 17'd124738;

  // The magnitude of the quotient is at most 233.
  localparam int unsigned QUOT_W = 8;

  // Threshold reset values.
  localparam logic signed [TEMP_W-1:0] TEMP_MIN_RST  = 9'sd0;
  localparam logic signed [TEMP_W-1:0] TEMP_HIGH_RST = 9'sd40;
  localparam logic signed [TEMP_W-1:0] TEMP_MAX_RST  = 9'sd60;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_TEMP_MIN  = 2'd0,
    REG_TEMP_HIGH = 2'd1,
    REG_TEMP_MAX  = 2'd2
  } reg_idx_t;

  // Urgency codes.
  typedef enum logic [1:0] {
    URG_NORMAL   = 2'd0,
    URG_ELEVATED = 2'd1,
    URG_URGENT   = 2'd2
  } urgency_t;

endpackage

`default_nettype wire

/* hdl/averaged_temperature_alarm.sv */
// Averaged temperature alarm.
// Samples arrive on the s_ stream, one 12-bit converter reading per transfer.
// Each sample enters a window of the last AVG_DEPTH readings; the window
// average is converted to degrees and checked against three thresholds.
// Every input transfer gives exactly one result transfer on the m_ stream,
// carrying the signed temperature, its low byte and an urgency code.
// Thresholds are to be written through the cfg_ channel only while no item is
// in flight; the block does not enforce this. cfg_ready is always high.
// The sum, average, quotient and output registers lie between the input
// transfer and m_tvalid. Throughput is one item per cycle while m_tready is
// high, in a four-stage pipeline: running sum, average by reciprocal multiply,
// scaling and division by 269, then threshold compare into the output register.
// Reset fills the window with 25, clears the pipeline and restores the
// thresholds to 0, 40 and 60. When the receiver stalls, stages fill up in
// turn and s_tready drops only once every stage holds an item.
`default_nettype none

module averaged_temperature_alarm #(
  parameter int unsigned AVG_DEPTH = ata_pkg::AVG_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Sample stream. s_tdata: [11:0] adc_sample.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,
  // Result stream. m_tdata: [8:0] temperature_c, [16:9] temperature_byte,
  // [18:17] urgency.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [23:0] m_tdata,
  // Threshold writes.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [8:0]  cfg_data
);

  localparam int unsigned SAMPLE_W = ata_pkg::SAMPLE_W;
  localparam int unsigned TEMP_W   = ata_pkg::TEMP_W;
  localparam int unsigned LOG_D    = $clog2(AVG_DEPTH);
  localparam int unsigned SUM_W    = SAMPLE_W + LOG_D;
  // Exact reciprocal of AVG_DEPTH for SUM_W-bit numerators.
  localparam int unsigned DIV_SH   = SUM_W + LOG_D;
  localparam int unsigned RCP_W    = SUM_W + 1;
  localparam logic [RCP_W-1:0] AVG_RCP =
    RCP_W'(((64'd1 << DIV_SH) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH));
  localparam int unsigned PROD_W   = SUM_W + RCP_W;
  localparam int unsigned CPROD_W  = ata_pkg::SCALED_W + ata_pkg::CONV_RCP_W;

  // Pipeline valid bits and stage enables.
  logic v1, v2, v3, v4;
  logic adv1, adv2, adv3, adv4;

  // Thresholds.
  logic signed [TEMP_W-1:0] temp_min, temp_high, temp_max;

  // Stage data.
  logic [SUM_W-1:0]             sum;
  logic [PROD_W-1:0]            avg_prod;
  logic [SAMPLE_W-1:0]          avg;
  logic signed [ata_pkg::DIFF_W-1:0] diff;
  logic [SAMPLE_W-1:0]          diff_mag;
  logic [ata_pkg::SCALED_W-1:0] scaled;
  logic [CPROD_W-1:0]           conv_prod;
  logic [ata_pkg::QUOT_W-1:0]   quot;
  logic                         neg;
  logic signed [TEMP_W-1:0]     temp;
  ata_pkg::urgency_t            urg;

  // Handshake: a stage moves when it is empty or the next one moves.
  assign adv4      = !v4 || m_tready;
  assign adv3      = !v3 || adv4;
  assign adv2      = !v2 || adv3;
  assign adv1      = !v1 || adv2;
  assign s_tready  = adv1;
  assign m_tvalid  = v4;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (adv1) begin
        v1 <= s_tvalid;
      end
      if (adv2) begin
        v2 <= v1;
      end
      if (adv3) begin
        v3 <= v2;
      end
      if (adv4) begin
        v4 <= v3;
      end
    end
  end

  // Threshold registers; only the low nine bits of the data are kept.
  always_ff @(posedge clk) begin
    if (rst) begin
      temp_min  <= ata_pkg::TEMP_MIN_RST;
      temp_high <= ata_pkg::TEMP_HIGH_RST;
      temp_max  <= ata_pkg::TEMP_MAX_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ata_pkg::REG_TEMP_MIN:  temp_min  <= cfg_data;
        ata_pkg::REG_TEMP_HIGH: temp_high <= cfg_data;
        ata_pkg::REG_TEMP_MAX:  temp_max  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage 1: window and running sum, updated on each input transfer.
  ata_window #(
    .AVG_DEPTH (AVG_DEPTH),
    .SUM_W     (SUM_W)
  ) u_window (
    .clk    (clk),
    .rst    (rst),
    .push   (s_tvalid && s_tready),
    .sample (s_tdata[SAMPLE_W-1:0]),
    .sum    (sum)
  );

  // Stage 2: average as sum times the reciprocal of the depth.
  assign avg_prod = PROD_W'(sum) * PROD_W'(AVG_RCP);

  always_ff @(posedge clk) begin
    if (adv2) begin
      avg <= avg_prod[DIV_SH +: SAMPLE_W];
    end
  end

  // Stage 3: offset, scale by 25 with shifts, divide magnitude by 269.
  assign diff     = ata_pkg::CONV_OFFSET - $signed({1'b0, avg});
  assign diff_mag = diff[ata_pkg::DIFF_W-1] ? SAMPLE_W'(-diff) : SAMPLE_W'(diff);
  assign scaled   = (ata_pkg::SCALED_W'(diff_mag) << 4)
                  + (ata_pkg::SCALED_W'(diff_mag) << 3)
                  + ata_pkg::SCALED_W'(diff_mag);
  assign conv_prod = CPROD_W'(scaled) * CPROD_W'(ata_pkg::CONV_RCP);

  always_ff @(posedge clk) begin
    if (adv3) begin
      quot <= conv_prod[ata_pkg::CONV_SH +: ata_pkg::QUOT_W];
      neg  <= diff[ata_pkg::DIFF_W-1];
    end
  end

  // Stage 4: restore the sign, which truncates toward zero, and grade it.
  assign temp = neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

  always_comb begin
    priority if (temp < temp_min) begin
      urg = ata_pkg::URG_URGENT;
    end else if (temp >= temp_max) begin
      urg = ata_pkg::URG_URGENT;
    end else if (temp >= temp_high) begin
      urg = ata_pkg::URG_ELEVATED;
    end else begin
      urg = ata_pkg::URG_NORMAL;
    end
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      m_tdata <= {5'd0, urg, temp[7:0], temp};
    end
  end

endmodule

`default_nettype wire

/* hdl/ata_window.sv */
`default_nettype none

module ata_window #(
  parameter int unsigned AVG_DEPTH = ata_pkg::AVG_DEPTH_DEF,
  parameter int unsigned SUM_W     = ata_pkg::SAMPLE_W + $clog2(AVG_DEPTH)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  input  wire logic [ata_pkg::SAMPLE_W-1:0]  sample,
  output logic      [SUM_W-1:0]              sum
);

  localparam logic [SUM_W-1:0] SUM_RST = SUM_W'(ata_pkg::RESET_SAMPLE * AVG_DEPTH);
  localparam logic [ata_pkg::SAMPLE_W-1:0] ENTRY_RST =
    ata_pkg::SAMPLE_W'(ata_pkg::RESET_SAMPLE);

  logic [ata_pkg::SAMPLE_W-1:0] taps [AVG_DEPTH];
  logic [SUM_W-1:0]             sum_next;

  // Running sum: drop the oldest sample and add the new one.
  assign sum_next = sum - SUM_W'(taps[0]) + SUM_W'(sample);

  // Shift line of the last samples, oldest at tap zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AVG_DEPTH; i++) begin
        taps[i] <= ENTRY_RST;
      end
      sum <= SUM_RST;
    end else if (push) begin
      for (int i = 0; i < AVG_DEPTH - 1; i++) begin
        taps[i] <= taps[i+1];
      end
      taps[AVG_DEPTH-1] <= sample;
      sum               <= sum_next;
    end
  end

endmodule

`default_nettype wire

/* dv/ata_result_checker.sv */
`default_nettype none

module ata_result_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [15:0] s_tdata,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [23:0] m_tdata,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [8:0]  cfg_data,
  output int               fail_count,
  output int               outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN_DEPTH  = ata_pkg::AVG_DEPTH_DEF;
  localparam int FILL_VALUE = 25;
  localparam int DEG_OFFSET = 2508;
  localparam int DEG_SCALE  = 25;
  localparam int DEG_DIV    = 269;

  typedef struct packed {
    logic signed [ata_pkg::TEMP_W-1:0] temp;
    logic [7:0]                        temp_byte;
    ata_pkg::urgency_t                 level;
  } reading_t;

  // Shadow copy of the sample window and the thresholds.
  logic [ata_pkg::SAMPLE_W-1:0]      window [WIN_DEPTH];
  int unsigned                       window_total;
  logic signed [ata_pkg::TEMP_W-1:0] thr_min;
  logic signed [ata_pkg::TEMP_W-1:0] thr_high;
  logic signed [ata_pkg::TEMP_W-1:0] thr_max;

  // Readings owed by the block, oldest first.
  reading_t due_readings[$];

  // Push one sample into the window and work out the reading it produces.
  function automatic reading_t absorb_sample(input logic [ata_pkg::SAMPLE_W-1:0] sample);
    int unsigned mean;
    int          deg;
    int          k;
    reading_t    r;
    window_total = window_total - window[0] + sample;
    for (k = 0; k < WIN_DEPTH - 1; k++) begin
      window[k] = window[k + 1];
    end
    window[WIN_DEPTH - 1] = sample;
    mean = window_total / WIN_DEPTH;
    // Signed division truncates toward zero, as the conversion requires.
    deg = ((DEG_OFFSET - int'(mean)) * DEG_SCALE) / DEG_DIV;
    r.temp      = deg[ata_pkg::TEMP_W-1:0];
    r.temp_byte = deg[7:0];
    // The low threshold wins over the high marks, whatever their order.
    if (deg < thr_min) begin
      r.level = ata_pkg::URG_URGENT;
    end else if (deg >= thr_max) begin
      r.level = ata_pkg::URG_URGENT;
    end else if (deg >= thr_high) begin
      r.level = ata_pkg::URG_ELEVATED;
    end else begin
      r.level = ata_pkg::URG_NORMAL;
    end
    return r;
  endfunction

  // Watch all three channels at the rising edge.
  always @(posedge clk) begin
    reading_t got;
    reading_t want;
    if (rst) begin
      foreach (window[k]) window[k] = ata_pkg::SAMPLE_W'(FILL_VALUE);
      window_total = FILL_VALUE * WIN_DEPTH;
      thr_min      = ata_pkg::TEMP_MIN_RST;
      thr_high     = ata_pkg::TEMP_HIGH_RST;
      thr_max      = ata_pkg::TEMP_MAX_RST;
      due_readings.delete();
    end else begin
      // Compare a result transfer with the oldest reading owed.
      if (m_tvalid && m_tready) begin
        got.temp      = m_tdata[8:0];
        got.temp_byte = m_tdata[16:9];
        got.level     = ata_pkg::urgency_t'(m_tdata[18:17]);
        if (due_readings.size() == 0) begin
          $display("%0t: unexpected result: temp %0d byte 0x%02h urgency %0d",
                   $realtime, got.temp, got.temp_byte, got.level);
          fail_count++;
        end else begin
          want = due_readings.pop_front();
          if (got !== want) begin
            $display("%0t: result mismatch: expected temp %0d byte 0x%02h urgency %0d",
                     $realtime, want.temp, want.temp_byte, want.level);
            $display("%0t:                  actual temp %0d byte 0x%02h urgency %0d",
                     $realtime, got.temp, got.temp_byte, got.level);
            fail_count++;
          end
        end
      end
      // Each sample transfer owes exactly one reading.
      if (s_tvalid && s_tready) begin
        due_readings.push_back(absorb_sample(s_tdata[ata_pkg::SAMPLE_W-1:0]));
      end
      // Threshold writes; an unused index changes nothing.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ata_pkg::REG_TEMP_MIN:  thr_min  = cfg_data;
          ata_pkg::REG_TEMP_HIGH: thr_high = cfg_data;
          ata_pkg::REG_TEMP_MAX:  thr_max  = cfg_data;
          default: ;
        endcase
      end
    end
    outstanding = due_readings.size();
  end

endmodule

`default_nettype wire

/* dv/tb_averaged_temperature_alarm.sv */
`default_nettype none

module tb_averaged_temperature_alarm;
  timeunit 1ns;
  timeprecision 1ps;

  import ata_pkg::*;

  localparam int          NUM_PHASES  = 8;
  localparam int          PHASE_ITEMS = 230;
  localparam int          HOLD_CYCLES = 60;
  localparam int          DRAIN_TAIL  = 8;
  localparam int unsigned CYCLE_LIMIT = 200000;
  // An index with no register behind it.
  localparam logic [1:0]  REG_SPARE   = 2'd3;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata   = '0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [23:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [8:0]  cfg_data  = '0;

  int          fail_count;
  int          outstanding;
  int          send_idle   = 0;
  int          recv_stall  = 0;
  int          hold_asked  = 0;
  int          hold_served = 0;
  int          hold_count  = 0;
  int unsigned cycle_count = 0;

  averaged_temperature_alarm i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ata_result_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result receiver: random stalls, plus long hold-offs on request.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_asked != hold_served) begin
      m_tready <= 1'b0;
      if (hold_count == HOLD_CYCLES - 1) begin
        hold_count  <= 0;
        hold_served <= hold_served + 1;
      end else begin
        hold_count <= hold_count + 1;
      end
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // Offer one sample, with random idle cycles before it, and wait for its transfer.
  // Called and returning at a falling edge.
  task automatic push_sample(input logic [15:0] word);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Write one threshold register.
  task automatic write_threshold(input logic [1:0] idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[8:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Stop offering samples until every reading has come back.
  task automatic settle();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  // Mostly runs of samples near one level, so the average walks the whole
  // scale; the rest is uniform noise.
  task automatic run_phase(input int count);
    int level;
    int span;
    int jitter;
    int value;
    int k;
    int sent;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 20) begin
        push_sample({4'h0, 12'($urandom_range(4095))});
        sent++;
      end else begin
        case ($urandom_range(9))
          0:       level = 0;
          1:       level = 4095;
          default: level = $urandom_range(4095);
        endcase
        span   = $urandom_range(4, 16);
        jitter = $urandom_range(64);
        for (k = 0; k < span && sent < count; k++) begin
          value = level + int'($urandom_range(2 * jitter)) - jitter;
          if (value < 0) begin
            value = 0;
          end else if (value > 4095) begin
            value = 4095;
          end
          push_sample({4'h0, value[11:0]});
          sent++;
        end
      end
    end
  endtask

  // Stimulus and verdict.
  initial begin
    int phase;
    int k;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // A write to an unused index must leave the thresholds alone.
    write_threshold(REG_SPARE, -1);

    // Directed: bits above the sample field are ignored.
    push_sample(16'hF019);
    push_sample(16'hA9CC);
    // Full scale fills the window: coldest reading, below the minimum.
    for (k = 0; k < 8; k++) push_sample(16'h0FFF);
    // Zero fills the window: hottest reading, above the maximum.
    for (k = 0; k < 8; k++) push_sample(16'h0000);
    // Step back toward mid scale; the reading stays above the maximum.
    for (k = 0; k < 4; k++) push_sample(16'h0A00);
    settle();

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      // Thresholds change only with nothing in flight.
      settle();
      case (phase)
        0: ;
        1: begin
          write_threshold(REG_TEMP_MIN, -147);
          write_threshold(REG_TEMP_HIGH, 233);
          write_threshold(REG_TEMP_MAX, 233);
        end
        2: begin
          // Outside the reachable range.
          write_threshold(REG_TEMP_MIN, -256);
          write_threshold(REG_TEMP_HIGH, -256);
          write_threshold(REG_TEMP_MAX, 255);
        end
        3: begin
          // Inverted order: the low threshold must take priority.
          write_threshold(REG_TEMP_MIN, 255);
          write_threshold(REG_TEMP_HIGH, 0);
          write_threshold(REG_TEMP_MAX, -256);
        end
        4: begin
          write_threshold(REG_TEMP_MIN, -20);
          write_threshold(REG_TEMP_HIGH, 20);
          write_threshold(REG_TEMP_MAX, 80);
        end
        7: begin
          write_threshold(REG_TEMP_MIN, $urandom_range(511));
          write_threshold(REG_TEMP_HIGH, $urandom_range(511));
          write_threshold(REG_TEMP_MAX, $urandom_range(511));
          write_threshold(REG_SPARE, $urandom_range(511));
        end
        default: begin
          write_threshold(REG_TEMP_MIN, int'($urandom_range(150)) - 147);
          write_threshold(REG_TEMP_HIGH, int'($urandom_range(200)) - 50);
          write_threshold(REG_TEMP_MAX, int'($urandom_range(233)));
        end
      endcase

      case (phase % 4)
        0: begin
          send_idle  = 0;
          recv_stall <= 0;
        end
        1: begin
          send_idle  = 75;
          recv_stall <= 0;
        end
        2: begin
          send_idle  = 0;
          recv_stall <= 75;
        end
        default: begin
          send_idle  = 29;
          recv_stall <= 29;
        end
      endcase

      // Hold the receiver off while samples keep coming, so the pipeline backs up.
      if (phase == 2 || phase == 4) begin
        hold_asked <= hold_asked + 1;
      end
      run_phase(PHASE_ITEMS);
    end

    settle();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
